// ===== rtl/nrhp_pkg.sv =====
package nrhp_pkg;

    localparam int TDATA_W = 104;
    localparam int TUSER_W = 4;

    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_TYPE_LEN = 3'd1;
    localparam logic [2:0] KIND_PLEN     = 3'd2;
    localparam logic [2:0] KIND_ID_LEN   = 3'd3;
    localparam logic [2:0] KIND_TYPE     = 3'd4;
    localparam logic [2:0] KIND_ID       = 3'd5;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd6;
    localparam logic [2:0] KIND_IGNORED  = 3'd7;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_NONCANON  = 2'd2;

    localparam int FLAG_SR_BIT = 4;
    localparam int FLAG_IL_BIT = 3;
    localparam logic [31:0] SHORT_LIMIT = 32'd256;

endpackage

// ===== rtl/ndef_record_header_parser_unit.sv =====
// Parses the first NDEF record of a buffer at one byte per clock cycle. Every
// accepted byte yields exactly one result in the next cycle, tagged with the field
// it belongs to; the byte that completes the record, or the buffer's last byte
// if the record is still open, also carries the status and the declared lengths.
// The phase and length counters are updated in one pass between the input and
// the result register, so a new byte is taken every cycle; o_s_tready drops
// only while the result register is full and the downstream side stalls.
module ndef_record_header_parser_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // data_byte[7:0]
    input  logic [7:0]                   i_s_tdata,
    // buffer_end
    input  logic                         i_s_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // byte_out[7:0], parse_status[9:8], record_length[42:10], header_flags[50:43],
    // type_length[58:51], id_length[66:59], payload_length[98:67], zeros[103:99]
    output logic [nrhp_pkg::TDATA_W-1:0] o_m_tdata,
    // field_kind[2:0], record_done[3]
    output logic [nrhp_pkg::TUSER_W-1:0] o_m_tuser
);
    import nrhp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TYPELEN = 3'd1,
        PH_PLEN    = 3'd2,
        PH_IDLEN   = 3'd3,
        PH_TYPE    = 3'd4,
        PH_ID      = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_IDLE    = 3'd7
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] remaining;
        logic        complete;
    } t_body;

    function automatic t_body enter_body(t_phase from, logic [7:0] tl, logic [7:0] il,
                                         logic [31:0] pl);
        t_body b;
        b.complete = 1'b0;
        if (from == PH_TYPE && tl != 8'd0) begin
            b.phase = PH_TYPE;
            b.remaining = {24'd0, tl};
        end else if ((from == PH_TYPE || from == PH_ID) && il != 8'd0) begin
            b.phase = PH_ID;
            b.remaining = {24'd0, il};
        end else if (pl != 32'd0) begin
            b.phase = PH_PAYLOAD;
            b.remaining = pl;
        end else begin
            b.phase = PH_IDLE;
            b.remaining = 32'd0;
            b.complete = 1'b1;
        end
        return b;
    endfunction

    t_phase      r_phase, n_phase;
    logic [7:0]  r_header, n_header;
    logic [7:0]  r_type_len, n_type_len;
    logic [7:0]  r_id_len, n_id_len;
    logic [31:0] r_payload_len, n_payload_len;
    logic [31:0] r_remaining, n_remaining;
    logic [1:0]  r_len_idx, n_len_idx;
    logic [32:0] r_consumed, n_consumed;
    logic        r_reported, n_reported;

    logic                r_m_tvalid;
    logic [TDATA_W-1:0]  r_m_tdata, n_m_tdata;
    logic [TUSER_W-1:0]  r_m_tuser, n_m_tuser;

    logic        s_accept;
    logic        complete;
    logic        done;
    logic [1:0]  status;
    logic [31:0] dec_remaining;
    t_body       body;

    assign o_s_tready = i_rst_n && (!r_m_tvalid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign dec_remaining = r_remaining - 32'd1;

    always_comb begin
        n_phase       = r_phase;
        n_header      = r_header;
        n_type_len    = r_type_len;
        n_id_len      = r_id_len;
        n_payload_len = r_payload_len;
        n_remaining   = r_remaining;
        n_len_idx     = r_len_idx;
        n_consumed    = (r_phase != PH_IDLE) ? r_consumed + 33'd1 : r_consumed;
        n_reported    = r_reported;
        complete      = 1'b0;
        body          = '0;

        unique case (r_phase)
            PH_HEADER: begin
                n_header      = i_s_tdata;
                n_type_len    = 8'd0;
                n_id_len      = 8'd0;
                n_payload_len = 32'd0;
                n_phase       = PH_TYPELEN;
            end
            PH_TYPELEN: begin
                n_type_len    = i_s_tdata;
                n_payload_len = 32'd0;
                n_len_idx     = 2'd0;
                n_phase       = PH_PLEN;
            end
            PH_PLEN: begin
                n_payload_len = {r_payload_len[23:0], i_s_tdata};
                if (r_header[FLAG_SR_BIT] || r_len_idx == 2'd3) begin
                    n_len_idx = 2'd0;
                    if (r_header[FLAG_IL_BIT]) begin
                        n_phase = PH_IDLEN;
                    end else begin
                        body        = enter_body(PH_TYPE, r_type_len, r_id_len, n_payload_len);
                        n_phase     = body.phase;
                        n_remaining = body.remaining;
                        complete    = body.complete;
                    end
                end else begin
                    n_len_idx = r_len_idx + 2'd1;
                end
            end
            PH_IDLEN: begin
                n_id_len    = i_s_tdata;
                body        = enter_body(PH_TYPE, r_type_len, i_s_tdata, r_payload_len);
                n_phase     = body.phase;
                n_remaining = body.remaining;
                complete    = body.complete;
            end
            PH_TYPE, PH_ID: begin
                n_remaining = dec_remaining;
                if (dec_remaining == 32'd0) begin
                    body = enter_body((r_phase == PH_TYPE) ? PH_ID : PH_PAYLOAD,
                                      r_type_len, r_id_len, r_payload_len);
                    n_phase     = body.phase;
                    n_remaining = body.remaining;
                    complete    = body.complete;
                end
            end
            PH_PAYLOAD: begin
                n_remaining = dec_remaining;
                if (dec_remaining == 32'd0) begin
                    n_phase  = PH_IDLE;
                    complete = 1'b1;
                end
            end
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
        endcase

        done = complete || (i_s_tlast && !r_reported);
        if (complete) begin
            status = (!n_header[FLAG_SR_BIT] && n_payload_len < SHORT_LIMIT) ?
                     STATUS_NONCANON : STATUS_OK;
        end else begin
            status = STATUS_TRUNCATED;
        end
        if (done) begin
            n_reported = 1'b1;
        end

        n_m_tdata = '0;
        n_m_tdata[7:0] = i_s_tdata;
        if (done) begin
            n_m_tdata[9:8]   = status;
            n_m_tdata[42:10] = n_consumed;
            n_m_tdata[50:43] = n_header;
            n_m_tdata[58:51] = n_type_len;
            n_m_tdata[66:59] = n_header[FLAG_IL_BIT] ? n_id_len : 8'd0;
            n_m_tdata[98:67] = n_payload_len;
        end
        n_m_tuser = {done, 3'(r_phase)};

        if (i_s_tlast) begin
            n_phase       = PH_HEADER;
            n_header      = 8'd0;
            n_type_len    = 8'd0;
            n_id_len      = 8'd0;
            n_payload_len = 32'd0;
            n_remaining   = 32'd0;
            n_len_idx     = 2'd0;
            n_consumed    = 33'd0;
            n_reported    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_header      <= 8'd0;
            r_type_len    <= 8'd0;
            r_id_len      <= 8'd0;
            r_payload_len <= 32'd0;
            r_remaining   <= 32'd0;
            r_len_idx     <= 2'd0;
            r_consumed    <= 33'd0;
            r_reported    <= 1'b0;
            r_m_tvalid    <= 1'b0;
        end else begin
            if (s_accept) begin
                r_phase       <= n_phase;
                r_header      <= n_header;
                r_type_len    <= n_type_len;
                r_id_len      <= n_id_len;
                r_payload_len <= n_payload_len;
                r_remaining   <= n_remaining;
                r_len_idx     <= n_len_idx;
                r_consumed    <= n_consumed;
                r_reported    <= n_reported;
                r_m_tvalid    <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_tdata <= n_m_tdata;
            r_m_tuser <= n_m_tuser;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

// ===== rtl/nrhp_checker.sv =====
module nrhp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         o_s_tready,
    input logic [7:0]                   i_s_tdata,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [nrhp_pkg::TDATA_W-1:0] o_m_tdata,
    input logic [nrhp_pkg::TUSER_W-1:0] o_m_tuser
);
    import nrhp_pkg::*;

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // Every accepted request shows up as a result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted request produced no result");

    // The result carries the byte of the request it belongs to.
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_s_tvalid && o_s_tready |=> o_m_tdata[7:0] == $past(i_s_tdata))
        else $error("byte_out does not match the accepted byte");

    // Without record_done the status and length fields stay zero.
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[3] |-> o_m_tdata[TDATA_W-1:8] == '0)
        else $error("status fields set on a result without record_done");

endmodule

bind ndef_record_header_parser_unit nrhp_checker u_nrhp_checker (.*);
